[src/msde_pkg.sv]
// ----------------------------------------------------------------------------
// msde_pkg
// Shared opcodes, function codes, ALU operations and stage payload types
// for the MIPS-subset decode and execute pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package msde_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned RLEN = 5;

   // primary opcodes
   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTIU = 6'h0b;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LB    = 6'h20;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SW    = 6'h2b;

   // R-type function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   localparam logic [RLEN-1:0] LINK_REG = 5'd31;

   typedef enum logic [3:0] {
      ALU_AND,
      ALU_OR,
      ALU_NOR,
      ALU_ADD,
      ALU_SUB,
      ALU_SLT,
      ALU_SLL,
      ALU_SRL,
      ALU_PASSB
   } alu_op_type;

   // control bundle carried down the pipe with each item
   typedef struct packed {
      alu_op_type      alu_op;
      logic [4:0]      shamt;
      logic [RLEN-1:0] dest_reg;
      logic            reg_write;
      logic            mem_read;
      logic            mem_write;
      logic            byte_access;
      logic            is_jump;
      logic            is_jump_register;
      logic            is_beq;
      logic            is_bne;
   } ctrl_type;

   // decode -> execute
   typedef struct packed {
      ctrl_type        ctrl;
      logic [XLEN-1:0] opa;
      logic [XLEN-1:0] opb;
      logic [XLEN-1:0] pc4;
      logic [XLEN-1:0] br_off;
      logic [XLEN-1:0] jump_target;
   } dec_type;

   // execute -> resolve
   typedef struct packed {
      ctrl_type        ctrl;
      logic [XLEN-1:0] alu_result;
      logic [XLEN-1:0] branch_target;
      logic [XLEN-1:0] jump_target;
   } exe_type;

endpackage

`default_nettype wire

[src/msde_decode.sv]
// ----------------------------------------------------------------------------
// msde_decode
// First stage: split the instruction word, build controls and operands.
// ----------------------------------------------------------------------------
`default_nettype none

module msde_decode (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic [msde_pkg::XLEN-1:0] instruction,
   input  wire logic [msde_pkg::XLEN-1:0] pc,
   input  wire logic [msde_pkg::XLEN-1:0] rs_value,
   input  wire logic [msde_pkg::XLEN-1:0] rt_value,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output msde_pkg::dec_type              out_data
);
   import msde_pkg::*;

   logic            valid_ff;
   dec_type         data_ff;
   dec_type         data_in;
   logic [5:0]      op;
   logic [5:0]      funct;
   logic [15:0]     imm;
   logic [XLEN-1:0] simm;
   logic [XLEN-1:0] zimm;
   logic [XLEN-1:0] pc4;

   assign op    = instruction[31:26];
   assign funct = instruction[5:0];
   assign imm   = instruction[15:0];
   assign simm  = {{(XLEN-16){imm[15]}}, imm};
   assign zimm  = {{(XLEN-16){1'b0}}, imm};
   assign pc4   = pc + XLEN'(4);

   always_comb begin
      data_in                        = '0;
      data_in.opa                    = rs_value;
      data_in.opb                    = simm;
      data_in.pc4                    = pc4;
      data_in.br_off                 = {simm[XLEN-3:0], 2'b00};
      data_in.jump_target            = pc4;
      data_in.ctrl.alu_op            = ALU_AND;
      data_in.ctrl.shamt             = instruction[10:6];
      data_in.ctrl.dest_reg          = instruction[20:16];
      unique case (op)
         OP_RTYPE: begin
            data_in.opb                = rt_value;
            data_in.ctrl.dest_reg      = instruction[15:11];
            data_in.ctrl.reg_write     = 1'b1;
            unique case (funct)
               FN_AND:  data_in.ctrl.alu_op = ALU_AND;
               FN_OR:   data_in.ctrl.alu_op = ALU_OR;
               FN_NOR:  data_in.ctrl.alu_op = ALU_NOR;
               FN_ADDU: data_in.ctrl.alu_op = ALU_ADD;
               FN_SUBU: data_in.ctrl.alu_op = ALU_SUB;
               FN_SLTU: data_in.ctrl.alu_op = ALU_SLT;
               FN_SLL:  data_in.ctrl.alu_op = ALU_SLL;
               FN_SRL:  data_in.ctrl.alu_op = ALU_SRL;
               FN_JR: begin
                  data_in.ctrl.alu_op           = ALU_OR;
                  data_in.ctrl.is_jump_register = 1'b1;
                  data_in.ctrl.reg_write        = 1'b0;
               end
               default: data_in.ctrl.alu_op = ALU_AND;
            endcase
         end
         OP_J, OP_JAL: begin
            data_in.ctrl.alu_op  = ALU_PASSB;
            data_in.ctrl.is_jump = 1'b1;
            data_in.jump_target  = {pc[XLEN-1:XLEN-4], instruction[25:0], 2'b00};
            data_in.opb          = '0;
            if (op == OP_JAL) begin
               data_in.opb            = pc4;
               data_in.ctrl.dest_reg  = LINK_REG;
               data_in.ctrl.reg_write = 1'b1;
            end
         end
         OP_ADDIU: begin
            data_in.ctrl.alu_op    = ALU_ADD;
            data_in.ctrl.reg_write = 1'b1;
         end
         OP_ANDI: begin
            data_in.opb            = zimm;
            data_in.ctrl.alu_op    = ALU_AND;
            data_in.ctrl.reg_write = 1'b1;
         end
         OP_ORI: begin
            data_in.opb            = zimm;
            data_in.ctrl.alu_op    = ALU_OR;
            data_in.ctrl.reg_write = 1'b1;
         end
         OP_LUI: begin
            data_in.opb            = {imm, 16'h0000};
            data_in.ctrl.alu_op    = ALU_PASSB;
            data_in.ctrl.reg_write = 1'b1;
         end
         OP_SLTIU: begin
            data_in.ctrl.alu_op    = ALU_SLT;
            data_in.ctrl.reg_write = 1'b1;
         end
         OP_LW, OP_LB: begin
            data_in.ctrl.alu_op      = ALU_ADD;
            data_in.ctrl.reg_write   = 1'b1;
            data_in.ctrl.mem_read    = 1'b1;
            data_in.ctrl.byte_access = (op == OP_LB);
         end
         OP_SW, OP_SB: begin
            data_in.ctrl.alu_op      = ALU_ADD;
            data_in.ctrl.mem_write   = 1'b1;
            data_in.ctrl.byte_access = (op == OP_SB);
         end
         OP_BEQ, OP_BNE: begin
            data_in.opb          = rt_value;
            data_in.ctrl.alu_op  = ALU_SUB;
            data_in.ctrl.is_beq  = (op == OP_BEQ);
            data_in.ctrl.is_bne  = (op == OP_BNE);
         end
         default: data_in.ctrl.alu_op = ALU_AND;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[src/msde_execute.sv]
// ----------------------------------------------------------------------------
// msde_execute
// Second stage: ALU operation and branch target add.
// ----------------------------------------------------------------------------
`default_nettype none

module msde_execute (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire msde_pkg::dec_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output msde_pkg::exe_type      out_data
);
   import msde_pkg::*;

   logic            valid_ff;
   exe_type         data_ff;
   exe_type         data_in;
   logic [XLEN-1:0] diff;

   assign diff = in_data.opa - in_data.opb;

   always_comb begin
      data_in.ctrl          = in_data.ctrl;
      data_in.jump_target   = in_data.jump_target;
      data_in.branch_target = in_data.pc4 + in_data.br_off;
      unique case (in_data.ctrl.alu_op)
         ALU_AND:   data_in.alu_result = in_data.opa & in_data.opb;
         ALU_OR:    data_in.alu_result = in_data.opa | in_data.opb;
         ALU_NOR:   data_in.alu_result = ~(in_data.opa | in_data.opb);
         ALU_ADD:   data_in.alu_result = in_data.opa + in_data.opb;
         ALU_SUB:   data_in.alu_result = diff;
         ALU_SLT:   data_in.alu_result = {{(XLEN-1){1'b0}}, diff[XLEN-1]};
         ALU_SLL:   data_in.alu_result = in_data.opb << in_data.ctrl.shamt;
         ALU_SRL:   data_in.alu_result = in_data.opb >> in_data.ctrl.shamt;
         ALU_PASSB: data_in.alu_result = in_data.opb;
         default:   data_in.alu_result = in_data.opa & in_data.opb;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[src/msde_resolve.sv]
// ----------------------------------------------------------------------------
// msde_resolve
// Third stage: branch decision from the difference, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msde_resolve (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire msde_pkg::exe_type         in_data,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic                           branch_taken,
   output msde_pkg::exe_type              out_data
);
   import msde_pkg::*;

   logic    valid_ff;
   exe_type data_ff;
   logic    taken_ff;
   logic    taken_in;
   logic    is_zero;

   assign is_zero  = (in_data.alu_result == '0);
   assign taken_in = (in_data.ctrl.is_beq && is_zero) || (in_data.ctrl.is_bne && !is_zero);

   assign in_ready     = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign out_data     = data_ff;
   assign branch_taken = taken_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff  <= in_data;
         taken_ff <= taken_in;
      end
   end

endmodule

`default_nettype wire

[src/mips_subset_decode_execute.sv]
// ----------------------------------------------------------------------------
// mips_subset_decode_execute: MIPS-subset decode and execute pipeline
// Pipeline: decode, execute, resolve, each a registered stage between req accept and rsp_valid.
// Throughput: 1 item per cycle while rsp_ready stays high; each stage refills as it drains under stall.
// Reset: synchronous active-high reset empties all three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_decode_execute (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [msde_pkg::XLEN-1:0] req_instruction,
   input  wire logic [msde_pkg::XLEN-1:0] req_pc,
   input  wire logic [msde_pkg::XLEN-1:0] req_rs_value,
   input  wire logic [msde_pkg::XLEN-1:0] req_rt_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [msde_pkg::XLEN-1:0]      rsp_alu_result,
   output logic                           rsp_branch_taken,
   output logic [msde_pkg::XLEN-1:0]      rsp_branch_target,
   output logic [msde_pkg::XLEN-1:0]      rsp_jump_target,
   output logic                           rsp_is_jump,
   output logic                           rsp_is_jump_register,
   output logic [msde_pkg::RLEN-1:0]      rsp_dest_reg,
   output logic                           rsp_reg_write,
   output logic                           rsp_mem_read,
   output logic                           rsp_mem_write,
   output logic                           rsp_byte_access
);
   import msde_pkg::*;

   // stage handshakes: each stage takes a new item when it is empty or
   // when the stage after it takes its current one
   logic    dec_valid;
   logic    dec_ready;
   dec_type dec_data;
   logic    exe_valid;
   logic    exe_ready;
   exe_type exe_data;
   exe_type res_data;

   // decode: opcode/funct to controls, immediates, pc+4, jump target
   msde_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .instruction (req_instruction),
      .pc          (req_pc),
      .rs_value    (req_rs_value),
      .rt_value    (req_rt_value),
      .out_valid   (dec_valid),
      .out_ready   (dec_ready),
      .out_data    (dec_data)
   );

   // execute: ALU and branch target adder
   msde_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (exe_valid),
      .out_ready (exe_ready),
      .out_data  (exe_data)
   );

   // resolve: zero test for beq/bne, hold the finished item for the consumer
   msde_resolve u_resolve (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (exe_valid),
      .in_ready     (exe_ready),
      .in_data      (exe_data),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .branch_taken (rsp_branch_taken),
      .out_data     (res_data)
   );

   assign rsp_alu_result       = res_data.alu_result;
   assign rsp_branch_target    = res_data.branch_target;
   assign rsp_jump_target      = res_data.jump_target;
   assign rsp_is_jump          = res_data.ctrl.is_jump;
   assign rsp_is_jump_register = res_data.ctrl.is_jump_register;
   assign rsp_dest_reg         = res_data.ctrl.dest_reg;
   assign rsp_reg_write        = res_data.ctrl.reg_write;
   assign rsp_mem_read         = res_data.ctrl.mem_read;
   assign rsp_mem_write        = res_data.ctrl.mem_write;
   assign rsp_byte_access      = res_data.ctrl.byte_access;

   // a load always writes back, a store never does
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_read |-> rsp_reg_write && !rsp_mem_write)
      else $error("load without write-back or with store");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mem_write |-> !rsp_reg_write && !rsp_is_jump)
      else $error("store with write-back or jump");

   // byte width only applies to memory operations
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_access |-> rsp_mem_read || rsp_mem_write)
      else $error("byte access on non-memory item");

   // jumps do not branch, jr never writes back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_is_jump || rsp_is_jump_register) |->
         !rsp_branch_taken && !(rsp_is_jump && rsp_is_jump_register))
      else $error("jump controls inconsistent");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_jump_register |-> !rsp_reg_write)
      else $error("jr with write-back");

   // a link write goes to the return address register with pc+4; the low
   // target bits of a jal are its branch offset, so pc+4 is recovered from
   // the branch target
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_jump && rsp_reg_write |->
         rsp_dest_reg == LINK_REG && rsp_alu_result == rsp_branch_target
            - {{(XLEN-18){rsp_jump_target[17]}}, rsp_jump_target[17:0]})
      else $error("jal link register wrong");

endmodule

`default_nettype wire

[verif/mips_subset_decode_execute_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_decode_execute_tb: self-checking bench for the decode/execute
// A directed set of instructions covers every supported opcode and funct,
// the field extremes and the odd corners (sign-of-difference compare, address
// wrap, unknown codes). It is followed by random instruction words, most of
// them with supported encodings. Each accepted item is run through a local
// model of the stage, and every response is compared field by field in order.
// ----------------------------------------------------------------------------

module mips_subset_decode_execute_tb;

   import msde_pkg::*;

   // encodings that the stage does not decode
   localparam logic [5:0] FN_UNUSED = 6'h3f;
   localparam logic [5:0] OP_UNUSED = 6'h3f;

   // both sides run without any gaps while the item count is in this window
   localparam int unsigned STEADY_FROM = 300;
   localparam int unsigned STEADY_TO   = 450;
   localparam int unsigned RANDOM_ITEMS = 650;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] pc;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
   } instr_item_type;

   typedef struct packed {
      logic [31:0] alu_result;
      logic        branch_taken;
      logic [31:0] branch_target;
      logic [31:0] jump_target;
      logic        is_jump;
      logic        is_jump_register;
      logic [4:0]  dest_reg;
      logic        reg_write;
      logic        mem_read;
      logic        mem_write;
      logic        byte_access;
   } stage_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction = '0;
   logic [31:0] req_pc = '0;
   logic [31:0] req_rs_value = '0;
   logic [31:0] req_rt_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_alu_result;
   logic        rsp_branch_taken;
   logic [31:0] rsp_branch_target;
   logic [31:0] rsp_jump_target;
   logic        rsp_is_jump;
   logic        rsp_is_jump_register;
   logic [4:0]  rsp_dest_reg;
   logic        rsp_reg_write;
   logic        rsp_mem_read;
   logic        rsp_mem_write;
   logic        rsp_byte_access;

   instr_item_type   instr_queue[$];      // items waiting to be driven
   stage_result_type predicted_q[$];      // results owed by the stage, oldest first
   instr_item_type   cur_item;
   stage_result_type observed;
   stage_result_type expected;
   int unsigned      total_items;
   int unsigned      accepted_count = 0;
   int unsigned      result_count = 0;
   int unsigned      mismatch_count = 0;

   mips_subset_decode_execute uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_instruction      (req_instruction),
      .req_pc               (req_pc),
      .req_rs_value         (req_rs_value),
      .req_rt_value         (req_rt_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_alu_result       (rsp_alu_result),
      .rsp_branch_taken     (rsp_branch_taken),
      .rsp_branch_target    (rsp_branch_target),
      .rsp_jump_target      (rsp_jump_target),
      .rsp_is_jump          (rsp_is_jump),
      .rsp_is_jump_register (rsp_is_jump_register),
      .rsp_dest_reg         (rsp_dest_reg),
      .rsp_reg_write        (rsp_reg_write),
      .rsp_mem_read         (rsp_mem_read),
      .rsp_mem_write        (rsp_mem_write),
      .rsp_byte_access      (rsp_byte_access)
   );

   // ------------------------------------------------------------------------
   // Stage model: decode one instruction and compute everything it produces
   // ------------------------------------------------------------------------
   function automatic stage_result_type execute_instruction(input instr_item_type it);
      logic [5:0]       op;
      logic [5:0]       funct;
      logic [4:0]       rt;
      logic [4:0]       rd;
      logic [4:0]       shamt;
      logic [31:0]      a;
      logic [31:0]      b;
      logic [31:0]      imm;
      logic [31:0]      simm;
      logic [31:0]      pc4;
      logic [31:0]      diff;
      stage_result_type r;
      op    = it.instruction[31:26];
      rt    = it.instruction[20:16];
      rd    = it.instruction[15:11];
      shamt = it.instruction[10:6];
      funct = it.instruction[5:0];
      a     = it.rs_value;
      b     = it.rt_value;
      imm   = {16'h0000, it.instruction[15:0]};
      simm  = {{16{it.instruction[15]}}, it.instruction[15:0]};
      pc4   = it.pc + 32'd4;

      r = '0;
      r.dest_reg      = rt;
      r.branch_target = pc4 + (simm << 2);   // computed for every instruction
      r.jump_target   = pc4;

      if (op == OP_RTYPE) begin
         r.dest_reg  = rd;
         r.reg_write = 1'b1;
         case (funct)
            FN_AND:  r.alu_result = a & b;
            FN_OR:   r.alu_result = a | b;
            FN_NOR:  r.alu_result = ~(a | b);
            FN_ADDU: r.alu_result = a + b;
            FN_SUBU: r.alu_result = a - b;
            FN_SLTU: begin
               // sign bit of the wrapped difference, not a true unsigned compare
               diff = a - b;
               r.alu_result = {31'd0, diff[31]};
            end
            FN_SLL:  r.alu_result = b << shamt;
            FN_SRL:  r.alu_result = b >> shamt;
            FN_JR: begin
               r.alu_result       = a | b;
               r.is_jump_register = 1'b1;
               r.reg_write        = 1'b0;
            end
            default: r.alu_result = a & b;   // unknown funct still writes rd
         endcase
      end else if (op == OP_J || op == OP_JAL) begin
         r.is_jump     = 1'b1;
         r.jump_target = {it.pc[31:28], it.instruction[25:0], 2'b00};
         if (op == OP_JAL) begin
            r.alu_result = pc4;
            r.dest_reg   = LINK_REG;
            r.reg_write  = 1'b1;
         end
      end else begin
         case (op)
            OP_ADDIU: begin
               r.alu_result = a + simm;
               r.reg_write  = 1'b1;
            end
            OP_ANDI: begin
               r.alu_result = a & imm;
               r.reg_write  = 1'b1;
            end
            OP_ORI: begin
               r.alu_result = a | imm;
               r.reg_write  = 1'b1;
            end
            OP_LUI: begin
               r.alu_result = {it.instruction[15:0], 16'h0000};
               r.reg_write  = 1'b1;
            end
            OP_SLTIU: begin
               diff = a - simm;
               r.alu_result = {31'd0, diff[31]};
               r.reg_write  = 1'b1;
            end
            OP_LW: begin
               r.alu_result = a + simm;
               r.reg_write  = 1'b1;
               r.mem_read   = 1'b1;
            end
            OP_LB: begin
               r.alu_result  = a + simm;
               r.reg_write   = 1'b1;
               r.mem_read    = 1'b1;
               r.byte_access = 1'b1;
            end
            OP_SW: begin
               r.alu_result = a + simm;
               r.mem_write  = 1'b1;
            end
            OP_SB: begin
               r.alu_result  = a + simm;
               r.mem_write   = 1'b1;
               r.byte_access = 1'b1;
            end
            OP_BEQ: begin
               r.alu_result   = a - b;
               r.branch_taken = (a == b);
            end
            OP_BNE: begin
               r.alu_result   = a - b;
               r.branch_taken = (a != b);
            end
            default: r.alu_result = a & simm;   // unknown opcode: no controls
         endcase
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Encoding and stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rd,
                                          input logic [4:0] shamt);
      return {OP_RTYPE, 5'd1, 5'd2, rd, shamt, fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rt,
                                          input logic [15:0] imm);
      return {op, 5'd3, rt, imm};
   endfunction

   task automatic add_item(input logic [31:0] ins, input logic [31:0] pc,
                           input logic [31:0] rs, input logic [31:0] rt);
      instr_item_type it;
      it.instruction = ins;
      it.pc          = pc;
      it.rs_value    = rs;
      it.rt_value    = rt;
      instr_queue.push_back(it);
   endtask

   // bias operands toward the values where wrap and sign effects show
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h8000_0000;
         3:       return 32'h7fff_ffff;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [5:0] known_funct(input int unsigned k);
      case (k)
         0:       return FN_AND;
         1:       return FN_OR;
         2:       return FN_NOR;
         3:       return FN_ADDU;
         4:       return FN_SUBU;
         5:       return FN_SLTU;
         6:       return FN_SLL;
         7:       return FN_SRL;
         default: return FN_JR;
      endcase
   endfunction

   function automatic logic [5:0] known_opcode(input int unsigned k);
      case (k)
         0:       return OP_J;
         1:       return OP_JAL;
         2:       return OP_ADDIU;
         3:       return OP_ANDI;
         4:       return OP_ORI;
         5:       return OP_LUI;
         6:       return OP_SLTIU;
         7:       return OP_LW;
         8:       return OP_LB;
         9:       return OP_SW;
         10:      return OP_SB;
         11:      return OP_BEQ;
         default: return OP_BNE;
      endcase
   endfunction

   // a gap on roughly 18 calls in a hundred, none inside the steady window
   function automatic bit take_gap(input int unsigned n);
      if (n >= STEADY_FROM && n < STEADY_TO)
         return 1'b0;
      return $urandom_range(99) < 18;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch at result %0d: %s expected 0x%08h got 0x%08h",
                  result_count, what, exp_val, act_val);
   endtask

   task automatic compare_results(input stage_result_type e, input stage_result_type a);
      if (e.alu_result !== a.alu_result)
         report_mismatch("alu_result", e.alu_result, a.alu_result);
      if (e.branch_taken !== a.branch_taken)
         report_mismatch("branch_taken", 32'(e.branch_taken), 32'(a.branch_taken));
      if (e.branch_target !== a.branch_target)
         report_mismatch("branch_target", e.branch_target, a.branch_target);
      if (e.jump_target !== a.jump_target)
         report_mismatch("jump_target", e.jump_target, a.jump_target);
      if (e.is_jump !== a.is_jump)
         report_mismatch("is_jump", 32'(e.is_jump), 32'(a.is_jump));
      if (e.is_jump_register !== a.is_jump_register)
         report_mismatch("is_jump_register", 32'(e.is_jump_register),
                         32'(a.is_jump_register));
      if (e.dest_reg !== a.dest_reg)
         report_mismatch("dest_reg", 32'(e.dest_reg), 32'(a.dest_reg));
      if (e.reg_write !== a.reg_write)
         report_mismatch("reg_write", 32'(e.reg_write), 32'(a.reg_write));
      if (e.mem_read !== a.mem_read)
         report_mismatch("mem_read", 32'(e.mem_read), 32'(a.mem_read));
      if (e.mem_write !== a.mem_write)
         report_mismatch("mem_write", 32'(e.mem_write), 32'(a.mem_write));
      if (e.byte_access !== a.byte_access)
         report_mismatch("byte_access", 32'(e.byte_access), 32'(a.byte_access));
   endtask

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Driver: present queued items, record a prediction at each accept
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_q.push_back(execute_instruction(cur_item));
            accepted_count++;
         end
         // load a new item only when the slot is free; otherwise hold the payload
         if (!req_valid || req_ready) begin
            if (instr_queue.size() > 0 && !take_gap(accepted_count)) begin
               cur_item        = instr_queue.pop_front();
               req_valid       <= 1'b1;
               req_instruction <= cur_item.instruction;
               req_pc          <= cur_item.pc;
               req_rs_value    <= cur_item.rs_value;
               req_rt_value    <= cur_item.rt_value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: stall at random, check each response against the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed.alu_result       = rsp_alu_result;
            observed.branch_taken     = rsp_branch_taken;
            observed.branch_target    = rsp_branch_target;
            observed.jump_target      = rsp_jump_target;
            observed.is_jump          = rsp_is_jump;
            observed.is_jump_register = rsp_is_jump_register;
            observed.dest_reg         = rsp_dest_reg;
            observed.reg_write        = rsp_reg_write;
            observed.mem_read         = rsp_mem_read;
            observed.mem_write        = rsp_mem_write;
            observed.byte_access      = rsp_byte_access;
            if (predicted_q.size() == 0) begin
               report_mismatch("response with nothing pending, alu_result", '0,
                               observed.alu_result);
            end else begin
               expected = predicted_q.pop_front();
               compare_results(expected, observed);
            end
            result_count++;
         end
         rsp_ready <= !take_gap(result_count);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      instr_item_type it;
      int unsigned    k;
      logic [31:0]    word;

      // every R-type funct at operand extremes
      add_item(r_word(FN_AND,  5'd31, 5'd0), 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
      add_item(r_word(FN_OR,   5'd0,  5'd0), 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
      add_item(r_word(FN_NOR,  5'd5,  5'd0), 32'h1000_0000, 32'h0000_0000, 32'h0000_0000);
      add_item(r_word(FN_ADDU, 5'd6,  5'd0), 32'h2000_0000, 32'hffff_ffff, 32'h0000_0001);
      add_item(r_word(FN_SUBU, 5'd7,  5'd0), 32'h3000_0000, 32'h0000_0000, 32'h0000_0001);
      // set-less-than follows the sign of the difference, even where that is wrong
      add_item(r_word(FN_SLTU, 5'd8,  5'd0), 32'h4000_0000, 32'h8000_0000, 32'h0000_0000);
      add_item(r_word(FN_SLTU, 5'd9,  5'd0), 32'h5000_0000, 32'h0000_0000, 32'h8000_0001);
      add_item(r_word(FN_SLL,  5'd10, 5'd31), 32'h6000_0000, 32'hffff_ffff, 32'h0000_0001);
      add_item(r_word(FN_SRL,  5'd11, 5'd31), 32'h7000_0000, 32'h0000_0000, 32'h8000_0000);
      add_item(r_word(FN_JR,   5'd12, 5'd0), 32'h8000_0000, 32'h1234_5678, 32'h0f0f_0000);
      add_item(r_word(FN_UNUSED, 5'd13, 5'd3), 32'h9000_0000, 32'hff00_ff00, 32'h0ff0_0ff0);
      // jumps: full target field under an upper pc nibble of ones, and a wrapping pc + 4
      add_item({OP_J, 26'h3ff_ffff}, 32'hffff_fff0, 32'h0, 32'h0);
      add_item({OP_JAL, 26'h000_0000}, 32'hffff_fffc, 32'h0, 32'h0);
      // immediates: sign-extended except for andi and ori
      add_item(i_word(OP_ADDIU, 5'd4,  16'h8000), 32'h0000_0004, 32'h0000_0000, 32'h0);
      add_item(i_word(OP_ANDI,  5'd31, 16'hffff), 32'h0000_0008, 32'hffff_ffff, 32'h0);
      add_item(i_word(OP_ORI,   5'd0,  16'h8000), 32'h0000_000c, 32'h0000_0000, 32'h0);
      add_item(i_word(OP_LUI,   5'd14, 16'hffff), 32'h0000_0010, 32'h5555_5555, 32'h0);
      add_item(i_word(OP_SLTIU, 5'd15, 16'h0001), 32'h0000_0014, 32'h0000_0000, 32'h0);
      // loads and stores, address wrapping both ways
      add_item(i_word(OP_LW, 5'd16, 16'h0004), 32'h0000_0018, 32'hffff_fffc, 32'h0);
      add_item(i_word(OP_LB, 5'd17, 16'hffff), 32'h0000_001c, 32'h0000_0000, 32'h0);
      add_item(i_word(OP_SW, 5'd18, 16'h7fff), 32'h0000_0020, 32'h7fff_ffff, 32'hffff_ffff);
      add_item(i_word(OP_SB, 5'd19, 16'h8000), 32'h0000_0024, 32'h8000_0000, 32'h0000_00ff);
      // branches taken and not taken; a backward offset from pc zero wraps the target
      add_item(i_word(OP_BEQ, 5'd20, 16'h8000), 32'h0000_0000, 32'hdead_beef, 32'hdead_beef);
      add_item(i_word(OP_BEQ, 5'd21, 16'h7fff), 32'hffff_fffc, 32'h0000_0001, 32'h0000_0000);
      add_item(i_word(OP_BNE, 5'd22, 16'hffff), 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff);
      add_item(i_word(OP_UNUSED, 5'd23, 16'h8001), 32'h0000_0028, 32'hffff_ffff, 32'h0);

      // random part: mostly supported encodings with random content, some raw words
      repeat (RANDOM_ITEMS) begin
         word = $urandom();
         k = $urandom_range(99);
         if (k < 40)
            word = {OP_RTYPE, word[25:6], known_funct($urandom_range(8))};
         else if (k < 90)
            word = {known_opcode($urandom_range(12)), word[25:0]};
         it.instruction = word;
         it.pc          = pick_operand();
         it.rs_value    = pick_operand();
         // equal operands often enough that beq and bne go both ways
         it.rt_value    = ($urandom_range(3) == 0) ? it.rs_value : pick_operand();
         instr_queue.push_back(it);
      end
      total_items = instr_queue.size();

      // drain: every item accepted, every prediction matched, then idle before the verdict
      while (accepted_count < total_items)
         @(negedge clock);
      while (predicted_q.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0 && predicted_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #400000;
      $display("tb: failure");
      $finish;
   end

endmodule
